@@ src/dcws_pkg.sv @@
// Shared types, register indexes, microcode encodings and the control store.
package dcws_pkg;

   localparam int DATA_W    = 32;
   localparam int REG_W     = 31;
   localparam int NUM_REGS  = 8;
   localparam int CSR_IDX_W = 4;
   localparam int STEP_W    = 4;

   localparam logic [CSR_IDX_W-1:0] REG_EMF_GAIN        = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TORQUE_GAIN     = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_FRICTION_TORQUE = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SPEED_TO_SLIP   = 4'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SLIP_GAIN       = 4'd4;
   localparam logic [CSR_IDX_W-1:0] REG_GRIP_LIMIT      = 4'd5;
   localparam logic [CSR_IDX_W-1:0] REG_TORQUE_TO_SPEED = 4'd6;
   localparam logic [CSR_IDX_W-1:0] REG_FORCE_TO_SPEED  = 4'd7;

   localparam logic [1:0] SEQ_NEXT     = 2'd0;
   localparam logic [1:0] SEQ_WAIT_REQ = 2'd1;
   localparam logic [1:0] SEQ_EMIT     = 2'd2;
   localparam logic [1:0] SEQ_JUMP     = 2'd3;

   localparam logic [3:0] MUL_NONE    = 4'd0;
   localparam logic [3:0] MUL_W_EMF   = 4'd1;
   localparam logic [3:0] MUL_FR_TTS  = 4'd2;
   localparam logic [3:0] MUL_T_TG    = 4'd3;
   localparam logic [3:0] MUL_W_STS   = 4'd4;
   localparam logic [3:0] MUL_T_SG    = 4'd5;
   localparam logic [3:0] MUL_TQ_TTS  = 4'd6;
   localparam logic [3:0] MUL_F_FTS   = 4'd7;
   localparam logic [3:0] MUL_W_STEP  = 4'd8;

   localparam logic [3:0] ALU_NONE    = 4'd0;
   localparam logic [3:0] ALU_LOAD    = 4'd1;
   localparam logic [3:0] ALU_NET     = 4'd2;
   localparam logic [3:0] ALU_DEAD    = 4'd3;
   localparam logic [3:0] ALU_TORQ    = 4'd4;
   localparam logic [3:0] ALU_GSDIFF  = 4'd5;
   localparam logic [3:0] ALU_FRIC    = 4'd6;
   localparam logic [3:0] ALU_FORCE   = 4'd7;
   localparam logic [3:0] ALU_ACC     = 4'd8;
   localparam logic [3:0] ALU_NEWW    = 4'd9;
   localparam logic [3:0] ALU_EMIT    = 4'd10;

   localparam logic [STEP_W-1:0] STEP_WAIT   = 4'd0;
   localparam logic [STEP_W-1:0] STEP_NET    = 4'd1;
   localparam logic [STEP_W-1:0] STEP_DEAD   = 4'd2;
   localparam logic [STEP_W-1:0] STEP_TORQ   = 4'd3;
   localparam logic [STEP_W-1:0] STEP_GSDIFF = 4'd4;
   localparam logic [STEP_W-1:0] STEP_FRIC   = 4'd5;
   localparam logic [STEP_W-1:0] STEP_FORCE  = 4'd6;
   localparam logic [STEP_W-1:0] STEP_ACC    = 4'd7;
   localparam logic [STEP_W-1:0] STEP_NEWW   = 4'd8;
   localparam logic [STEP_W-1:0] STEP_ANGLE  = 4'd9;
   localparam logic [STEP_W-1:0] STEP_EMIT   = 4'd10;

   typedef struct packed {
      logic signed [DATA_W-1:0] voltage;
      logic signed [DATA_W-1:0] ground_speed;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0]   ground_force;
      logic                       slipping;
      logic signed [DATA_W-1:0]   motor_torque;
      logic signed [DATA_W-1:0]   wheel_speed_out;
      logic signed [2*DATA_W-1:0] wheel_angle_out;
   } rsp_type;

   typedef struct packed {
      logic [1:0]        seq_op;
      logic [3:0]        mul_op;
      logic [3:0]        alu_op;
      logic [STEP_W-1:0] jump;
   } ucode_type;

   typedef struct packed {
      logic       en;
      logic [3:0] mul_op;
      logic [3:0] alu_op;
   } dp_ctrl_type;

   typedef struct packed {
      logic rsp_hold;
   } dp_stat_type;

   function automatic ucode_type ucode_rom(input logic [STEP_W-1:0] step);
      ucode_type word;
      case (step)
         STEP_WAIT:   word = '{SEQ_WAIT_REQ, MUL_W_EMF,  ALU_LOAD,   STEP_WAIT};
         STEP_NET:    word = '{SEQ_NEXT,     MUL_FR_TTS, ALU_NET,    STEP_WAIT};
         STEP_DEAD:   word = '{SEQ_NEXT,     MUL_T_TG,   ALU_DEAD,   STEP_WAIT};
         STEP_TORQ:   word = '{SEQ_NEXT,     MUL_W_STS,  ALU_TORQ,   STEP_WAIT};
         STEP_GSDIFF: word = '{SEQ_NEXT,     MUL_NONE,   ALU_GSDIFF, STEP_WAIT};
         STEP_FRIC:   word = '{SEQ_NEXT,     MUL_T_SG,   ALU_FRIC,   STEP_WAIT};
         STEP_FORCE:  word = '{SEQ_NEXT,     MUL_TQ_TTS, ALU_FORCE,  STEP_WAIT};
         STEP_ACC:    word = '{SEQ_NEXT,     MUL_F_FTS,  ALU_ACC,    STEP_WAIT};
         STEP_NEWW:   word = '{SEQ_NEXT,     MUL_NONE,   ALU_NEWW,   STEP_WAIT};
         STEP_ANGLE:  word = '{SEQ_NEXT,     MUL_W_STEP, ALU_NONE,   STEP_WAIT};
         STEP_EMIT:   word = '{SEQ_EMIT,     MUL_NONE,   ALU_EMIT,   STEP_WAIT};
         default:     word = '{SEQ_JUMP,     MUL_NONE,   ALU_NONE,   STEP_WAIT};
      endcase
      return word;
   endfunction

endpackage

@@ src/dc_motor_wheel_slip_step_core.sv @@
// Top level of the DC motor and slipping wheel step core with its register file.
//
// Usage:
//  - Request channel (req_valid/req_ready/req_data) takes one transaction per
//    simulation step: applied voltage and ground speed, signed Q16.16.
//  - Response channel (rsp_valid/rsp_ready/rsp_data) returns one transaction per
//    request: ground force, slip flag, motor torque, new wheel speed and angle.
//  - Registers are written through csr_we/csr_index/csr_wdata; the user must
//    write them only while idle, which the block does not enforce. Indexes
//    past the last register are ignored.
//  - A new request is not taken until the microcode program has run its eight
//    products through the single 32x32 multiplier in order.
//  - The next request is taken while a finished response waits; a stalled
//    receiver holds the program at its last step until the response is taken.
//  - Reset clears the wheel speed, the wheel angle, all registers and the
//    response valid flag, and returns the sequencer to its wait step.
module dc_motor_wheel_slip_step_core import dcws_pkg::*; #(
   parameter int TIME_STEP_Q = 655
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [REG_W-1:0]     csr_wdata
);

   logic [NUM_REGS-1:0][REG_W-1:0] csr_ff;
   logic [NUM_REGS-1:0][REG_W-1:0] csr_in;
   dp_ctrl_type                    ctrl;
   dp_stat_type                    stat;

   always_comb begin
      csr_in = csr_ff;
      if (csr_we && csr_index < CSR_IDX_W'(NUM_REGS)) begin
         csr_in[csr_index[$clog2(NUM_REGS)-1:0]] = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= '0;
      end else begin
         csr_ff <= csr_in;
      end
   end

   dcws_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .stat      (stat),
      .req_ready (req_ready),
      .ctrl      (ctrl)
   );

   dcws_dp #(
      .TIME_STEP_Q (TIME_STEP_Q)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .csr_regs  (csr_ff),
      .req_data  (req_data),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

@@ src/dcws_seq.sv @@
// Microcode sequencer: step counter, control store lookup and jumps.
module dcws_seq import dcws_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  dp_stat_type stat,
   output logic        req_ready,
   output dp_ctrl_type ctrl
);

   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] step_in;
   ucode_type         uword;

   assign uword       = ucode_rom(step_ff);
   assign req_ready   = (uword.seq_op == SEQ_WAIT_REQ);

   always_comb begin
      step_in     = step_ff;
      ctrl.en     = 1'b0;
      ctrl.mul_op = uword.mul_op;
      ctrl.alu_op = uword.alu_op;
      case (uword.seq_op)
         SEQ_WAIT_REQ: begin
            if (req_valid) begin
               ctrl.en = 1'b1;
               step_in = step_ff + STEP_W'(1);
            end
         end
         SEQ_NEXT: begin
            ctrl.en = 1'b1;
            step_in = step_ff + STEP_W'(1);
         end
         SEQ_EMIT: begin
            if (!stat.rsp_hold) begin
               ctrl.en = 1'b1;
               step_in = uword.jump;
            end
         end
         default: begin
            step_in = uword.jump;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_WAIT;
      end else begin
         step_ff <= step_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      step_ff <= STEP_EMIT)
      else $error("step counter beyond program");

   a_start: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> step_ff == STEP_NET)
      else $error("accepted transaction did not start program");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (step_ff == STEP_EMIT && stat.rsp_hold) |=> step_ff == STEP_EMIT)
      else $error("emit step left while result stalled");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (ctrl.en && ctrl.alu_op == ALU_EMIT) |-> !stat.rsp_hold)
      else $error("result register overwritten while stalled");
`endif

endmodule

@@ src/dcws_dp.sv @@
// Datapath: shared multiplier, saturating adders, state and result register.
module dcws_dp import dcws_pkg::*; #(
   parameter int TIME_STEP_Q = 655
) (
   input  logic                               clock,
   input  logic                               reset,
   input  dp_ctrl_type                        ctrl,
   input  logic [NUM_REGS-1:0][REG_W-1:0]     csr_regs,
   input  req_type                            req_data,
   input  logic                               rsp_ready,
   output dp_stat_type                        stat,
   output logic                               rsp_valid,
   output rsp_type                            rsp_data
);

   localparam logic signed [DATA_W-1:0] STEP_B = DATA_W'(TIME_STEP_Q);

   function automatic logic signed [DATA_W-1:0] sat50(input logic signed [49:0] v);
      logic signed [DATA_W-1:0] r;
      if (!v[49] && (|v[48:31])) begin
         r = {1'b0, {(DATA_W-1){1'b1}}};
      end else if (v[49] && !(&v[48:31])) begin
         r = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         r = v[DATA_W-1:0];
      end
      return r;
   endfunction

   logic signed [DATA_W-1:0]   emf, tg, fric, sts, sg, grip, tts, fts;
   logic signed [DATA_W-1:0]   mul_a, mul_b;
   logic signed [2*DATA_W-1:0] prod_ff, prod_in;
   logic signed [47:0]         prod_q;
   logic signed [DATA_W-1:0]   prod_sat;

   logic signed [DATA_W-1:0]   volt_ff, volt_in, gspd_ff, gspd_in;
   logic signed [DATA_W-1:0]   tmp_ff, tmp_in, dead_ff, dead_in;
   logic signed [DATA_W-1:0]   torq_ff, torq_in, force_ff, force_in;
   logic                       slip_ff, slip_in;
   logic signed [48:0]         acc_ff, acc_in;
   logic signed [DATA_W-1:0]   w_ff, w_in;
   logic signed [2*DATA_W-1:0] angle_ff, angle_in, angle_sum;
   logic                       rsp_valid_ff, rsp_valid_in;
   rsp_type                    rsp_data_ff, rsp_data_in;

   logic [DATA_W:0]            w_abs;
   logic                       fric_on, w_pos;
   logic signed [DATA_W-1:0]   torq_fric;

   assign emf  = {1'b0, csr_regs[REG_EMF_GAIN]};
   assign tg   = {1'b0, csr_regs[REG_TORQUE_GAIN]};
   assign fric = {1'b0, csr_regs[REG_FRICTION_TORQUE]};
   assign sts  = {1'b0, csr_regs[REG_SPEED_TO_SLIP]};
   assign sg   = {1'b0, csr_regs[REG_SLIP_GAIN]};
   assign grip = {1'b0, csr_regs[REG_GRIP_LIMIT]};
   assign tts  = {1'b0, csr_regs[REG_TORQUE_TO_SPEED]};
   assign fts  = {1'b0, csr_regs[REG_FORCE_TO_SPEED]};

   always_comb begin
      case (ctrl.mul_op)
         MUL_W_EMF:  begin mul_a = w_ff;     mul_b = emf;    end
         MUL_FR_TTS: begin mul_a = fric;     mul_b = tts;    end
         MUL_T_TG:   begin mul_a = tmp_ff;   mul_b = tg;     end
         MUL_W_STS:  begin mul_a = w_ff;     mul_b = sts;    end
         MUL_T_SG:   begin mul_a = tmp_ff;   mul_b = sg;     end
         MUL_TQ_TTS: begin mul_a = torq_ff;  mul_b = tts;    end
         MUL_F_FTS:  begin mul_a = force_ff; mul_b = fts;    end
         MUL_W_STEP: begin mul_a = w_ff;     mul_b = STEP_B; end
         default:    begin mul_a = '0;       mul_b = '0;     end
      endcase
   end

   assign prod_in  = mul_a * mul_b;
   assign prod_q   = prod_ff[2*DATA_W-1:16];
   assign prod_sat = sat50(50'(prod_q));

   assign w_abs     = w_ff[DATA_W-1] ? (DATA_W+1)'(0) - {w_ff[DATA_W-1], w_ff}
                                     : {1'b0, w_ff};
   assign fric_on   = w_abs > {1'b0, dead_ff};
   assign w_pos     = !w_ff[DATA_W-1] && (|w_ff);
   assign torq_fric = !fric_on ? torq_ff
                    : w_pos    ? sat50(50'(torq_ff) - 50'(fric))
                               : sat50(50'(torq_ff) + 50'(fric));
   assign angle_sum = angle_ff + prod_ff;

   always_comb begin
      volt_in      = volt_ff;
      gspd_in      = gspd_ff;
      tmp_in       = tmp_ff;
      dead_in      = dead_ff;
      torq_in      = torq_ff;
      force_in     = force_ff;
      slip_in      = slip_ff;
      acc_in       = acc_ff;
      w_in         = w_ff;
      angle_in     = angle_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;
      if (ctrl.en) begin
         case (ctrl.alu_op)
            ALU_LOAD: begin
               volt_in = req_data.voltage;
               gspd_in = req_data.ground_speed;
            end
            ALU_NET:    tmp_in  = sat50(50'(volt_ff) - 50'(prod_sat));
            ALU_DEAD:   dead_in = prod_sat;
            ALU_TORQ:   torq_in = prod_sat;
            ALU_GSDIFF: tmp_in  = sat50(50'(prod_sat) - 50'(gspd_ff));
            ALU_FRIC:   torq_in = torq_fric;
            ALU_FORCE: begin
               if (prod_sat > grip) begin
                  force_in = grip;
                  slip_in  = 1'b1;
               end else if (prod_sat < -grip) begin
                  force_in = -grip;
                  slip_in  = 1'b1;
               end else begin
                  force_in = prod_sat;
                  slip_in  = 1'b0;
               end
            end
            ALU_ACC:    acc_in = 49'(w_ff) + 49'(prod_q);
            ALU_NEWW:   w_in   = sat50(50'(acc_ff) - 50'(prod_q));
            ALU_EMIT: begin
               angle_in                    = angle_sum;
               rsp_valid_in                = 1'b1;
               rsp_data_in.ground_force    = force_ff;
               rsp_data_in.slipping        = slip_ff;
               rsp_data_in.motor_torque    = torq_ff;
               rsp_data_in.wheel_speed_out = w_ff;
               rsp_data_in.wheel_angle_out = angle_sum;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_ff         <= '0;
         angle_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         w_ff         <= w_in;
         angle_ff     <= angle_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.en && ctrl.mul_op != MUL_NONE) begin
         prod_ff <= prod_in;
      end
      volt_ff     <= volt_in;
      gspd_ff     <= gspd_in;
      tmp_ff      <= tmp_in;
      dead_ff     <= dead_in;
      torq_ff     <= torq_in;
      force_ff    <= force_in;
      slip_ff     <= slip_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign stat.rsp_hold = rsp_valid_ff && !rsp_ready;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data      = rsp_data_ff;

endmodule

@@ tb/tb_dc_motor_wheel_slip_step_core.sv @@
// Self-checking testbench for the DC motor and slipping wheel step core.
`timescale 1ns / 100ps

module tb_dc_motor_wheel_slip_step_core;
   import dcws_pkg::*;

   localparam int STEP_Q          = 655;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int RANDOM_PHASES   = 12;
   localparam int STEPS_PER_PHASE = 75;
   localparam int QUIET_FIRST     = 350;
   localparam int QUIET_LAST      = 500;
   localparam int DRAIN_CYCLES    = 20;
   localparam int ONE             = 65536;

   localparam longint Q_MAX = 64'sd2147483647;
   localparam longint Q_MIN = -64'sd2147483648;

   localparam logic signed [DATA_W-1:0] Q_HI = 32'sh7FFFFFFF;
   localparam logic signed [DATA_W-1:0] Q_LO = 32'sh80000000;
   localparam logic [REG_W-1:0]         G_HI = 31'h7FFFFFFF;

   localparam logic [CSR_IDX_W-1:0] REG_SPARE_FIRST = CSR_IDX_W'(NUM_REGS);
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_LAST  = '1;

   localparam rsp_type ALL_ZERO = '0;

   localparam int NOMINAL_GAIN [NUM_REGS] = '{
      32768, 131072, 6554, 16384, 655360, 327680, 6554, 3277
   };

   localparam logic signed [DATA_W-1:0] EXTREME_VALUES [5] = '{Q_HI, Q_LO, 0, -1, 1};

   typedef enum logic [1:0] {ROW_WRITE, ROW_STEP, ROW_ZERO} row_kind_type;

   typedef struct packed {
      row_kind_type             kind;
      logic [CSR_IDX_W-1:0]     index;
      logic [REG_W-1:0]         value;
      logic signed [DATA_W-1:0] voltage;
      logic signed [DATA_W-1:0] ground_speed;
   } dir_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_type              req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [REG_W-1:0]     csr_wdata = '0;

   logic [REG_W-1:0]         gain_regs [NUM_REGS];
   logic signed [DATA_W-1:0] wheel_speed_model = '0;
   logic [2*DATA_W-1:0]      wheel_angle_model = '0;
   rsp_type                  pending_results [$];
   dir_row_type              directed_rows [$];

   logic quiet = 1'b0;
   int   error_count = 0;
   int   cycle_count = 0;
   int   steps_sent = 0;
   int   steps_checked = 0;
   int   slips_seen = 0;
   int   settings_written = 0;

   dc_motor_wheel_slip_step_core #(.TIME_STEP_Q(STEP_Q)) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic longint clip32(input longint v);
      if (v > Q_MAX) return Q_MAX;
      if (v < Q_MIN) return Q_MIN;
      return v;
   endfunction

   function automatic longint qprod(input longint a, input longint b);
      return (a * b) >>> 16;
   endfunction

   function automatic rsp_type predict_wheel_step(input req_type item);
      longint emf, tg, fric, sts, sg, grip, tts, fts;
      longint volts, gspeed, w, back_v, net_v, torque_v, dead_v, mag, gs_v, grip_force, nw;
      rsp_type r;
      emf    = longint'(gain_regs[REG_EMF_GAIN]);
      tg     = longint'(gain_regs[REG_TORQUE_GAIN]);
      fric   = longint'(gain_regs[REG_FRICTION_TORQUE]);
      sts    = longint'(gain_regs[REG_SPEED_TO_SLIP]);
      sg     = longint'(gain_regs[REG_SLIP_GAIN]);
      grip   = longint'(gain_regs[REG_GRIP_LIMIT]);
      tts    = longint'(gain_regs[REG_TORQUE_TO_SPEED]);
      fts    = longint'(gain_regs[REG_FORCE_TO_SPEED]);
      volts  = longint'($signed(item.voltage));
      gspeed = longint'($signed(item.ground_speed));
      w      = longint'(wheel_speed_model);
      r      = '0;

      back_v   = clip32(qprod(w, emf));
      net_v    = clip32(volts - back_v);
      torque_v = clip32(qprod(net_v, tg));
      dead_v   = clip32(qprod(fric, tts));
      mag      = (w < 0) ? -w : w;
      if (mag > dead_v) begin
         torque_v = (w > 0) ? clip32(torque_v - fric) : clip32(torque_v + fric);
      end

      gs_v       = clip32(qprod(w, sts));
      grip_force = clip32(qprod(clip32(gs_v - gspeed), sg));
      if (grip_force > grip) begin
         grip_force = grip;
         r.slipping = 1'b1;
      end else if (grip_force < -grip) begin
         grip_force = -grip;
         r.slipping = 1'b1;
      end

      nw = clip32(w + qprod(torque_v, tts) - qprod(grip_force, fts));
      wheel_speed_model = 32'(nw);
      wheel_angle_model = wheel_angle_model + 64'(nw * STEP_Q);

      r.ground_force    = 32'(grip_force);
      r.motor_torque    = 32'(torque_v);
      r.wheel_speed_out = 32'(nw);
      r.wheel_angle_out = wheel_angle_model;
      return r;
   endfunction

   function automatic logic [REG_W-1:0] pick_gain(input int phase, input int idx);
      if (phase == 0) return '1;
      if (phase == 1) return '0;
      if (phase % 3 == 2) begin
         case ($urandom_range(3))
            0: return '0;
            1: return '1;
            default: return REG_W'($urandom);
         endcase
      end
      return REG_W'($urandom_range(NOMINAL_GAIN[idx] * 4));
   endfunction

   function automatic req_type random_step();
      req_type item;
      int pick;
      pick = $urandom_range(99);
      if (pick < 60) begin
         item.voltage      = $urandom_range(48 * ONE) - 24 * ONE;
         item.ground_speed = $urandom_range(8 * ONE) - 4 * ONE;
      end else if (pick < 85) begin
         item.voltage      = $urandom;
         item.ground_speed = $urandom;
      end else begin
         item.voltage      = EXTREME_VALUES[$urandom_range(4)];
         item.ground_speed = EXTREME_VALUES[$urandom_range(4)];
      end
      return item;
   endfunction

   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      csr_we    <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
      wait_idle();
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      if (idx < NUM_REGS) gain_regs[idx[2:0]] = val;
      settings_written++;
   endtask

   task automatic run_step(input req_type item, input logic zero_result);
      rsp_type want;
      @(negedge clock);
      csr_we <= 1'b0;
      while (!quiet && $urandom_range(99) < 14) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      want = predict_wheel_step(item);
      pending_results.push_back(zero_result ? ALL_ZERO : want);
      steps_sent++;
      quiet = (steps_sent >= QUIET_FIRST) && (steps_sent < QUIET_LAST);
   endtask

   task automatic check_field(input string name, input logic signed [63:0] want_v,
                              input logic signed [63:0] got_v);
      if (got_v !== want_v) begin
         $error("%s: expected %0d, got %0d", name, want_v, got_v);
         error_count++;
      end
   endtask

   always @(negedge clock) begin
      rsp_ready <= quiet || ($urandom_range(99) >= 14);
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $error("response transaction with no step outstanding");
            error_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("ground_force", want.ground_force, rsp_data.ground_force);
            check_field("slipping", want.slipping, rsp_data.slipping);
            check_field("motor_torque", want.motor_torque, rsp_data.motor_torque);
            check_field("wheel_speed_out", want.wheel_speed_out, rsp_data.wheel_speed_out);
            check_field("wheel_angle_out", want.wheel_angle_out, rsp_data.wheel_angle_out);
            steps_checked++;
            if (rsp_data.slipping) slips_seen++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_dc_motor_wheel_slip_step_core: done, errors");
         $finish;
      end
   end

   initial begin
      dir_row_type row;
      foreach (gain_regs[i]) gain_regs[i] = '0;

      directed_rows = '{
         '{ROW_ZERO,  REG_EMF_GAIN,        0,      Q_HI, Q_LO},
         '{ROW_ZERO,  REG_EMF_GAIN,        0,      Q_LO, Q_HI},
         '{ROW_ZERO,  REG_EMF_GAIN,        0,      0,    0},
         '{ROW_ZERO,  REG_EMF_GAIN,        0,      -1,   1},
         '{ROW_WRITE, REG_SPARE_FIRST,     G_HI,   0,    0},
         '{ROW_WRITE, REG_SPARE_LAST,      G_HI,   0,    0},
         '{ROW_ZERO,  REG_EMF_GAIN,        0,      Q_HI, Q_HI},
         '{ROW_ZERO,  REG_EMF_GAIN,        0,      Q_LO, Q_LO},
         '{ROW_WRITE, REG_EMF_GAIN,        G_HI,   0,    0},
         '{ROW_WRITE, REG_TORQUE_GAIN,     G_HI,   0,    0},
         '{ROW_WRITE, REG_FRICTION_TORQUE, G_HI,   0,    0},
         '{ROW_WRITE, REG_SPEED_TO_SLIP,   G_HI,   0,    0},
         '{ROW_WRITE, REG_SLIP_GAIN,       G_HI,   0,    0},
         '{ROW_WRITE, REG_GRIP_LIMIT,      G_HI,   0,    0},
         '{ROW_WRITE, REG_TORQUE_TO_SPEED, G_HI,   0,    0},
         '{ROW_WRITE, REG_FORCE_TO_SPEED,  G_HI,   0,    0},
         '{ROW_STEP,  REG_EMF_GAIN,        0,      Q_HI, Q_LO},
         '{ROW_STEP,  REG_EMF_GAIN,        0,      Q_LO, Q_HI},
         '{ROW_STEP,  REG_EMF_GAIN,        0,      Q_HI, Q_HI},
         '{ROW_STEP,  REG_EMF_GAIN,        0,      0,    0},
         '{ROW_STEP,  REG_EMF_GAIN,        0,      Q_LO, Q_LO},
         '{ROW_WRITE, REG_EMF_GAIN,        0,      0,    0},
         '{ROW_WRITE, REG_TORQUE_GAIN,     ONE,    0,    0},
         '{ROW_WRITE, REG_FRICTION_TORQUE, ONE/2,  0,    0},
         '{ROW_WRITE, REG_SPEED_TO_SLIP,   ONE,    0,    0},
         '{ROW_WRITE, REG_SLIP_GAIN,       ONE,    0,    0},
         '{ROW_WRITE, REG_GRIP_LIMIT,      G_HI,   0,    0},
         '{ROW_WRITE, REG_TORQUE_TO_SPEED, 0,      0,    0},
         '{ROW_WRITE, REG_FORCE_TO_SPEED,  ONE,    0,    0},
         '{ROW_STEP,  REG_EMF_GAIN,        0,      0,    ONE},
         '{ROW_STEP,  REG_EMF_GAIN,        0,      0,    ONE},
         '{ROW_STEP,  REG_EMF_GAIN,        0,      0,    -3*ONE},
         '{ROW_STEP,  REG_EMF_GAIN,        0,      2*ONE, 0},
         '{ROW_STEP,  REG_EMF_GAIN,        0,      0,    0},
         '{ROW_WRITE, REG_EMF_GAIN,        16384,  0,    0},
         '{ROW_WRITE, REG_TORQUE_GAIN,     2*ONE,  0,    0},
         '{ROW_WRITE, REG_FRICTION_TORQUE, 6554,   0,    0},
         '{ROW_WRITE, REG_SPEED_TO_SLIP,   ONE,    0,    0},
         '{ROW_WRITE, REG_SLIP_GAIN,       100*ONE, 0,   0},
         '{ROW_WRITE, REG_GRIP_LIMIT,      2*ONE,  0,    0},
         '{ROW_WRITE, REG_TORQUE_TO_SPEED, 6554,   0,    0},
         '{ROW_WRITE, REG_FORCE_TO_SPEED,  3277,   0,    0},
         '{ROW_STEP,  REG_EMF_GAIN,        0,      12*ONE, 0},
         '{ROW_STEP,  REG_EMF_GAIN,        0,      12*ONE, 5*ONE},
         '{ROW_STEP,  REG_EMF_GAIN,        0,      -12*ONE, -5*ONE},
         '{ROW_STEP,  REG_EMF_GAIN,        0,      0,    Q_LO},
         '{ROW_STEP,  REG_EMF_GAIN,        0,      0,    Q_HI},
         '{ROW_WRITE, REG_GRIP_LIMIT,      0,      0,    0},
         '{ROW_STEP,  REG_EMF_GAIN,        0,      ONE,  ONE}
      };

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         case (row.kind)
            ROW_WRITE: write_register(row.index, row.value);
            ROW_STEP:  run_step('{row.voltage, row.ground_speed}, 1'b0);
            default:   run_step('{row.voltage, row.ground_speed}, 1'b1);
         endcase
      end

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         for (int r = 0; r < NUM_REGS; r++) begin
            write_register(CSR_IDX_W'(r), pick_gain(phase, r));
         end
         if ($urandom_range(2) == 0) begin
            write_register(CSR_IDX_W'($urandom_range(REG_SPARE_LAST, REG_SPARE_FIRST)),
                           REG_W'($urandom));
         end
         for (int n = 0; n < STEPS_PER_PHASE; n++) run_step(random_step(), 1'b0);
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d motor steps (%0d checked, %0d slipping) over %0d register writes",
               steps_sent, steps_checked, slips_seen, settings_written);
      if (error_count == 0) begin
         $display("tb_dc_motor_wheel_slip_step_core: done, clean");
      end else begin
         $display("tb_dc_motor_wheel_slip_step_core: done, errors");
      end
      $finish;
   end

endmodule
